// ----- rtl/core/pbrc_pkg.sv -----
package pbrc_pkg;

    // Request action codes
    typedef logic [1:0] t_action;
    localparam t_action ACT_PART   = 2'd0;
    localparam t_action ACT_DIRECT = 2'd1;
    localparam t_action ACT_LOAD   = 2'd2;

    // Result status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_OK            = 3'd0;
    localparam t_status ST_BAD_ARG       = 3'd1;
    localparam t_status ST_NO_MEDIA      = 3'd2;
    localparam t_status ST_OUT_OF_BOUNDS = 3'd3;
    localparam t_status ST_READ_ONLY     = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TOTAL_SECTORS     = 3'd0;
    localparam t_cfg_idx CFG_MAX_BLOCKS        = 3'd1;
    localparam t_cfg_idx CFG_ALIGN_LOG2        = 3'd2;
    localparam t_cfg_idx CFG_SIZES_NONZERO     = 3'd3;
    localparam t_cfg_idx CFG_SECTOR_SIZE_MATCH = 3'd4;
    localparam t_cfg_idx CFG_MEDIA_PRESENT     = 3'd5;
    localparam t_cfg_idx CFG_MEDIA_READ_ONLY   = 3'd6;
    localparam t_cfg_idx CFG_DEVICE_READ_ONLY  = 3'd7;

    localparam int CFG_DATA_W = 64;

    typedef struct packed {
        t_action     action;
        logic [7:0]  part_index;
        logic [63:0] block_offset;
        logic [15:0] block_count;
        logic        is_write;
        logic [63:0] buffer_addr;
        logic [63:0] entry_start;
        logic [63:0] entry_length;
        logic        entry_read_only;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic        issue;
        logic [63:0] device_lba;
        logic [15:0] device_count;
    } t_rsp;

    typedef struct packed {
        logic [63:0] total_sectors;
        logic [15:0] max_blocks;
        logic [4:0]  align_log2;
        logic        sizes_nonzero;
        logic        sector_size_match;
        logic        media_present;
        logic        media_read_only;
        logic        device_read_only;
    } t_cfg;

    // One stored partition entry
    typedef struct packed {
        logic [63:0] first_sector;
        logic [63:0] sector_total;
        logic        write_protect;
    } t_part;

    // Entry as seen by the checker, with its loaded flag
    typedef struct packed {
        t_part part;
        logic  loaded;
    } t_entry;

endpackage

// ----- rtl/core/partition_block_request_checker.sv -----
// Partition block request checker. A request is taken at any clock edge with
// start high; busy stays low, so one item is taken every clock. Each item
// yields one result beat on o_rsp, marked by o_rsp_valid for exactly one
// cycle, after the stage and result registers. The receiver cannot stall and
// must take every beat. The figure of one item per clock is set by a single
// stage of check logic (one 64-bit add and the bound compares) and by the
// partition table, which is read at the edge an item is taken and written
// from the stage register by a load. Configuration writes land at once; the
// user must make them only while no item is in flight (not enforced here).
module partition_block_request_checker
    import pbrc_pkg::*;
#(
    parameter int NUM_PARTS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_req                  i_req,
    output logic                  o_rsp_valid,
    output t_rsp                  o_rsp,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;

    t_cfg   r_cfg;
    t_req   r_req;
    logic   r_valid;
    t_rsp   r_rsp;
    logic   r_done;
    logic   w_accept;
    logic   w_in_idx_ok;
    logic   w_idx_ok;
    logic   w_wr_en;
    t_part  w_wr_part;
    t_entry w_entry;
    t_rsp   n_rsp;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    assign w_in_idx_ok = {1'b0, i_req.part_index} < 9'(NUM_PARTS);
    assign w_idx_ok    = {1'b0, r_req.part_index} < 9'(NUM_PARTS);

    // Load entries from the stage register
    assign w_wr_en                 = r_valid && (r_req.action == ACT_LOAD) && w_idx_ok;
    assign w_wr_part.first_sector  = r_req.entry_start;
    assign w_wr_part.sector_total  = r_req.entry_length;
    assign w_wr_part.write_protect = r_req.entry_read_only;

    pbrc_table #(
        .NUM_PARTS (NUM_PARTS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_wr_en),
        .i_wr_idx   (r_req.part_index[IW-1:0]),
        .i_wr_part  (w_wr_part),
        .i_rd_en    (w_accept && w_in_idx_ok),
        .i_rd_idx   (i_req.part_index[IW-1:0]),
        .o_rd_entry (w_entry)
    );

    pbrc_check u_check (
        .i_req    (r_req),
        .i_idx_ok (w_idx_ok),
        .i_entry  (w_entry),
        .i_cfg    (r_cfg),
        .o_rsp    (n_rsp)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TOTAL_SECTORS:     r_cfg.total_sectors     <= i_cfg_data[63:0];
                CFG_MAX_BLOCKS:        r_cfg.max_blocks        <= i_cfg_data[15:0];
                CFG_ALIGN_LOG2:        r_cfg.align_log2        <= i_cfg_data[4:0];
                CFG_SIZES_NONZERO:     r_cfg.sizes_nonzero     <= i_cfg_data[0];
                CFG_SECTOR_SIZE_MATCH: r_cfg.sector_size_match <= i_cfg_data[0];
                CFG_MEDIA_PRESENT:     r_cfg.media_present     <= i_cfg_data[0];
                CFG_MEDIA_READ_ONLY:   r_cfg.media_read_only   <= i_cfg_data[0];
                CFG_DEVICE_READ_ONLY:  r_cfg.device_read_only  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Capture the request beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
    end

    // Advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_valid <= w_accept;
            r_done  <= r_valid;
        end
    end

    // Hold the result beat
    always_ff @(posedge i_clk) begin
        if (r_valid) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_done;
    assign o_rsp       = r_rsp;

endmodule

// ----- rtl/core/pbrc_table.sv -----
module pbrc_table
    import pbrc_pkg::*;
#(
    parameter int NUM_PARTS = 16,
    localparam int IW = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_idx,
    input  t_part         i_wr_part,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_idx,
    output t_entry        o_rd_entry
);

    t_part          mem [NUM_PARTS];
    logic [NUM_PARTS-1:0] r_loaded;
    t_part          r_rd_part;
    logic           r_rd_loaded;
    logic           w_bypass;

    // Same-edge write to the entry being read wins
    assign w_bypass = i_wr_en && (i_wr_idx == i_rd_idx);

    // Write entry storage
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_idx] <= i_wr_part;
        end
    end

    // Registered read of entry storage
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_part <= w_bypass ? i_wr_part : mem[i_rd_idx];
        end
    end

    // Track loaded entries, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded    <= '0;
            r_rd_loaded <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_loaded[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_loaded <= w_bypass ? 1'b1 : r_loaded[i_rd_idx];
            end
        end
    end

    assign o_rd_entry.part   = r_rd_part;
    assign o_rd_entry.loaded = r_rd_loaded;

endmodule

// ----- rtl/core/pbrc_check.sv -----
module pbrc_check
    import pbrc_pkg::*;
(
    input  t_req   i_req,
    input  logic   i_idx_ok,
    input  t_entry i_entry,
    input  t_cfg   i_cfg,
    output t_rsp   o_rsp
);

    logic [64:0] w_sum;
    logic [63:0] w_part_left;
    logic        w_part_bad;
    logic [63:0] w_lba;
    logic [63:0] w_dev_left;
    logic [31:0] w_mask;
    logic        w_misaligned;
    logic        w_dev_bad;
    logic        w_wr;
    t_status     w_dev_status;
    t_status     w_status;

    assign w_wr = i_req.is_write;

    // Partition range and translation
    assign w_sum       = {1'b0, i_req.block_offset} + {1'b0, i_entry.part.first_sector};
    assign w_part_left = i_entry.part.sector_total - i_req.block_offset;
    assign w_part_bad  = (i_req.block_offset >= i_entry.part.sector_total) ||
                         (w_part_left < {48'd0, i_req.block_count});

    // Device checks on the media address
    assign w_lba        = (i_req.action == ACT_DIRECT) ? i_req.block_offset : w_sum[63:0];
    assign w_dev_left   = i_cfg.total_sectors - w_lba;
    assign w_mask       = (32'd1 << i_cfg.align_log2) - 32'd1;
    assign w_misaligned = |(i_req.buffer_addr[31:0] & w_mask);
    assign w_dev_bad    = !i_cfg.sector_size_match ||
                          (w_lba >= i_cfg.total_sectors) ||
                          (i_req.block_count > i_cfg.max_blocks) ||
                          (w_dev_left < {48'd0, i_req.block_count}) ||
                          w_misaligned;

    always_comb begin
        if (!i_cfg.sizes_nonzero || (i_cfg.max_blocks == 16'd0)) begin
            w_dev_status = ST_BAD_ARG;
        end else if (!i_cfg.media_present) begin
            w_dev_status = ST_NO_MEDIA;
        end else if (w_dev_bad) begin
            w_dev_status = ST_BAD_ARG;
        end else if (w_wr && (i_cfg.media_read_only || i_cfg.device_read_only)) begin
            w_dev_status = ST_READ_ONLY;
        end else begin
            w_dev_status = ST_OK;
        end
    end

    // Pick status by action; partition requests check device read-only and media first
    always_comb begin
        case (i_req.action)
            ACT_LOAD: begin
                w_status = i_idx_ok ? ST_OK : ST_OUT_OF_BOUNDS;
            end
            ACT_DIRECT: begin
                w_status = w_dev_status;
            end
            ACT_PART: begin
                if (w_wr && i_cfg.device_read_only) begin
                    w_status = ST_READ_ONLY;
                end else if (!i_cfg.media_present) begin
                    w_status = ST_NO_MEDIA;
                end else if (!i_idx_ok || !i_entry.loaded) begin
                    w_status = ST_OUT_OF_BOUNDS;
                end else if (w_wr && i_entry.part.write_protect) begin
                    w_status = ST_READ_ONLY;
                end else if (w_part_bad || w_sum[64]) begin
                    w_status = ST_BAD_ARG;
                end else begin
                    w_status = w_dev_status;
                end
            end
            default: begin
                w_status = ST_BAD_ARG;
            end
        endcase
    end

    // Issue only passing requests, zero the address otherwise
    always_comb begin
        o_rsp.status = w_status;
        if ((i_req.action != ACT_LOAD) && (i_req.action == ACT_PART ||
            i_req.action == ACT_DIRECT) && (w_status == ST_OK)) begin
            o_rsp.issue        = 1'b1;
            o_rsp.device_lba   = w_lba;
            o_rsp.device_count = i_req.block_count;
        end else begin
            o_rsp.issue        = 1'b0;
            o_rsp.device_lba   = '0;
            o_rsp.device_count = '0;
        end
    end

endmodule

// ----- bench/partition_block_request_checker_test.sv -----
module partition_block_request_checker_test;
    import pbrc_pkg::*;

    localparam int NUM_PARTS = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES = 12;
    localparam int BEATS_PER_PHASE = 136;

    // The package names no code for the spare action value
    localparam t_action ACT_UNUSED = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_req                  i_req = '0;
    logic                  o_rsp_valid;
    t_rsp                  o_rsp;
    logic                  i_cfg_we = 1'b0;
    t_cfg_idx              i_cfg_idx = CFG_TOTAL_SECTORS;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int unsigned cycle_count = 0;
    int          sender_idle_pct = 0;

    partition_block_request_checker #(
        .NUM_PARTS(NUM_PARTS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Mirror of the register file and partition table; predicts each verdict
    class request_verdict_board;
        t_cfg        cfg = '0;
        logic [63:0] first_sector [NUM_PARTS];
        logic [63:0] sector_total [NUM_PARTS];
        logic        write_protect [NUM_PARTS];
        bit          loaded [NUM_PARTS];
        t_rsp        awaited [$];
        int unsigned errors;

        function void write_reg(t_cfg_idx idx, logic [63:0] data);
            case (idx)
                CFG_TOTAL_SECTORS:     cfg.total_sectors = data;
                CFG_MAX_BLOCKS:        cfg.max_blocks = data[15:0];
                CFG_ALIGN_LOG2:        cfg.align_log2 = data[4:0];
                CFG_SIZES_NONZERO:     cfg.sizes_nonzero = data[0];
                CFG_SECTOR_SIZE_MATCH: cfg.sector_size_match = data[0];
                CFG_MEDIA_PRESENT:     cfg.media_present = data[0];
                CFG_MEDIA_READ_ONLY:   cfg.media_read_only = data[0];
                CFG_DEVICE_READ_ONLY:  cfg.device_read_only = data[0];
                default: ;
            endcase
        endfunction

        // Media-level checks shared by direct and translated requests
        function t_status device_verdict(logic [63:0] lba, logic [15:0] count,
                                         logic wr, logic [63:0] buffer);
            logic [63:0] mask;
            mask = (64'd1 << cfg.align_log2) - 64'd1;
            if (!cfg.sizes_nonzero || cfg.max_blocks == 16'd0)
                return ST_BAD_ARG;
            if (!cfg.media_present)
                return ST_NO_MEDIA;
            if (!cfg.sector_size_match || lba >= cfg.total_sectors ||
                count > cfg.max_blocks || (cfg.total_sectors - lba) < 64'(count) ||
                (buffer & mask) != 64'd0)
                return ST_BAD_ARG;
            if (wr && (cfg.media_read_only || cfg.device_read_only))
                return ST_READ_ONLY;
            return ST_OK;
        endfunction

        // Predict the verdict of one accepted beat and update the table
        function void note_request(t_req r);
            t_rsp        want;
            t_status     st;
            logic [63:0] lba;
            logic [64:0] span;
            int          p;
            st = ST_BAD_ARG;
            lba = 64'd0;
            p = int'(r.part_index);
            case (r.action)
                ACT_LOAD: begin
                    if (p < NUM_PARTS) begin
                        first_sector[p] = r.entry_start;
                        sector_total[p] = r.entry_length;
                        write_protect[p] = r.entry_read_only;
                        loaded[p] = 1'b1;
                        st = ST_OK;
                    end else begin
                        st = ST_OUT_OF_BOUNDS;
                    end
                end
                ACT_DIRECT: begin
                    lba = r.block_offset;
                    st = device_verdict(lba, r.block_count, r.is_write, r.buffer_addr);
                end
                ACT_PART: begin
                    if (r.is_write && cfg.device_read_only) begin
                        st = ST_READ_ONLY;
                    end else if (!cfg.media_present) begin
                        st = ST_NO_MEDIA;
                    end else if (p >= NUM_PARTS || !loaded[p]) begin
                        st = ST_OUT_OF_BOUNDS;
                    end else if (r.is_write && write_protect[p]) begin
                        st = ST_READ_ONLY;
                    end else if (r.block_offset >= sector_total[p] ||
                                 (sector_total[p] - r.block_offset) < 64'(r.block_count)) begin
                        st = ST_BAD_ARG;
                    end else begin
                        span = {1'b0, r.block_offset} + {1'b0, first_sector[p]};
                        lba = span[63:0];
                        // Translation past 64 bits lies beyond any media
                        if (span[64])
                            st = ST_BAD_ARG;
                        else
                            st = device_verdict(lba, r.block_count, r.is_write,
                                                r.buffer_addr);
                    end
                end
                default: st = ST_BAD_ARG;
            endcase
            want = '0;
            want.status = st;
            if ((r.action == ACT_PART || r.action == ACT_DIRECT) && st == ST_OK) begin
                want.issue = 1'b1;
                want.device_lba = lba;
                want.device_count = r.block_count;
            end
            awaited.push_back(want);
        endfunction

        // Compare one result beat with the oldest prediction
        function void check_result(t_rsp got);
            t_rsp want;
            if (awaited.size() == 0) begin
                $error("result beat with nothing awaited: status %0d", got.status);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status) begin
                $error("status mismatch: expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.issue !== want.issue) begin
                $error("issue mismatch: expected %0b actual %0b", want.issue, got.issue);
                errors++;
            end
            if (got.device_lba !== want.device_lba) begin
                $error("device_lba mismatch: expected %h actual %h",
                       want.device_lba, got.device_lba);
                errors++;
            end
            if (got.device_count !== want.device_count) begin
                $error("device_count mismatch: expected %0d actual %0d",
                       want.device_count, got.device_count);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    request_verdict_board board = new;

    always #10 i_clk = ~i_clk;

    // Watch the ports: results, register writes and accepted beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_rsp_valid === 1'b1)
                board.check_result(o_rsp);
            if (i_cfg_we)
                board.write_reg(i_cfg_idx, i_cfg_data);
            if (start && busy === 1'b0)
                board.note_request(i_req);
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("partition_block_request_checker verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random value below n, leaning on both ends; n must be nonzero
    function automatic logic [63:0] pick_below(input logic [63:0] n);
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return n - 64'd1;
            default: return rand64() % n;
        endcase
    endfunction

    // Mostly aligned to the current setting, sometimes anything
    function automatic logic [63:0] pick_buffer();
        if ($urandom_range(0, 6) == 0)
            return rand64();
        return rand64() & ~((64'd1 << board.cfg.align_log2) - 64'd1);
    endfunction

    // Random count up to the largest worth asking for, given the room left
    function automatic logic [15:0] pick_count(input logic [63:0] room, input bit fits);
        logic [63:0] cap;
        cap = (board.cfg.max_blocks == 16'd0) ? 64'd65535 : 64'(board.cfg.max_blocks);
        if (fits && room < cap)
            cap = room;
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom);
        return 16'($urandom_range(cap == 64'd0 ? 0 : 1, 32'(cap)));
    endfunction

    function automatic t_req noise_req(input t_action a);
        t_req r;
        r.action = a;
        r.part_index = 8'($urandom);
        r.block_offset = rand64();
        r.block_count = 16'($urandom);
        r.is_write = 1'($urandom);
        r.buffer_addr = rand64();
        r.entry_start = rand64();
        r.entry_length = rand64();
        r.entry_read_only = 1'($urandom);
        return r;
    endfunction

    function automatic t_req cmd_req(input t_action a, input logic [7:0] idx,
                                     input logic [63:0] offset, input logic [15:0] count,
                                     input logic wr, input logic [63:0] buffer);
        t_req r;
        r = noise_req(a);
        r.part_index = idx;
        r.block_offset = offset;
        r.block_count = count;
        r.is_write = wr;
        r.buffer_addr = buffer;
        return r;
    endfunction

    function automatic t_req entry_req(input logic [7:0] idx, input logic [63:0] first,
                                       input logic [63:0] len, input logic ro);
        t_req r;
        r = noise_req(ACT_LOAD);
        r.part_index = idx;
        r.entry_start = first;
        r.entry_length = len;
        r.entry_read_only = ro;
        return r;
    endfunction

    // Entry that mostly fits the media, sometimes wild or near the top
    function automatic t_req make_load(input logic [7:0] idx);
        logic [63:0] tot;
        logic [63:0] first;
        logic [63:0] len;
        tot = board.cfg.total_sectors;
        case ($urandom_range(0, 9))
            0: begin
                first = rand64();
                len = rand64();
            end
            1: begin
                first = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 50));
                len = rand64();
            end
            2: begin
                first = rand64();
                len = 64'($urandom_range(0, 64));
            end
            default: begin
                if (tot == 64'd0) begin
                    first = 64'd0;
                    len = 64'($urandom_range(0, 500));
                end else begin
                    first = pick_below(tot);
                    len = 64'd1 + pick_below(tot - first);
                end
            end
        endcase
        return entry_req(idx, first, len, 1'($urandom_range(0, 3) == 0));
    endfunction

    // Partition request that mostly stays inside a loaded entry
    function automatic t_req make_part(input logic [7:0] idx);
        t_req        r;
        logic [63:0] len;
        r = cmd_req(ACT_PART, idx, rand64(), 16'd0, 1'($urandom), pick_buffer());
        len = board.sector_total[idx];
        if (len != 64'd0 && $urandom_range(0, 9) != 0)
            r.block_offset = pick_below(len);
        r.block_count = pick_count(len - r.block_offset, r.block_offset < len);
        return r;
    endfunction

    // Direct request that mostly stays on the media
    function automatic t_req make_direct();
        t_req        r;
        logic [63:0] tot;
        tot = board.cfg.total_sectors;
        r = cmd_req(ACT_DIRECT, 8'($urandom), rand64(), 16'd0, 1'($urandom), pick_buffer());
        if (tot != 64'd0 && $urandom_range(0, 6) != 0)
            r.block_offset = pick_below(tot);
        r.block_count = pick_count(tot - r.block_offset, r.block_offset < tot);
        return r;
    endfunction

    function automatic t_req next_item();
        logic [7:0] idx;
        int         roll;
        idx = 8'($urandom_range(0, NUM_PARTS - 1));
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return make_load(8'($urandom_range(0, 255)));
        if (roll < 12)
            return noise_req(ACT_UNUSED);
        if (roll < 18)
            return noise_req(ACT_PART);
        if (roll < 55) begin
            // Load an empty slot before asking for it
            if (!board.loaded[idx])
                return make_load(idx);
            return make_part(idx);
        end
        return make_direct();
    endfunction

    function automatic t_cfg phase_config(input int ph);
        t_cfg c;
        c.total_sectors = 64'd4096;
        c.max_blocks = 16'd256;
        c.align_log2 = 5'd2;
        c.sizes_nonzero = 1'b1;
        c.sector_size_match = 1'b1;
        c.media_present = 1'b1;
        c.media_read_only = 1'b0;
        c.device_read_only = 1'b0;
        case (ph)
            0: ;
            1: begin
                c.total_sectors = 64'hFFFF_FFFF_FFFF_FFFF;
                c.max_blocks = 16'hFFFF;
                c.align_log2 = 5'd31;
                c.media_read_only = 1'b1;
                c.device_read_only = 1'b1;
            end
            2: c = '0;
            3: c.sector_size_match = 1'b0;
            4: begin
                c.media_present = 1'b0;
                c.device_read_only = 1'b1;
            end
            5: c.sizes_nonzero = 1'b0;
            6: begin
                c.total_sectors = 64'd1;
                c.max_blocks = 16'd1;
                c.align_log2 = 5'd0;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: c.total_sectors = 64'($urandom_range(1, 100000));
                    1: c.total_sectors = rand64();
                    2: c.total_sectors = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1000));
                    default: c.total_sectors = 64'($urandom_range(1, 2000));
                endcase
                c.max_blocks = $urandom_range(0, 1) ? 16'($urandom_range(1, 65535))
                                                    : 16'($urandom_range(1, 32));
                c.align_log2 = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                           : 5'($urandom_range(0, 9));
                c.sizes_nonzero = 1'($urandom_range(0, 9) != 0);
                c.sector_size_match = 1'($urandom_range(0, 9) != 0);
                c.media_present = 1'($urandom_range(0, 9) != 0);
                c.media_read_only = 1'($urandom_range(0, 3) == 0);
                c.device_read_only = 1'($urandom_range(0, 3) == 0);
            end
        endcase
        return c;
    endfunction

    // Idle cycle by cycle at the phase's rate, then present one beat and hold until taken
    task automatic send_beat(input t_req r);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Stop sending and wait for every predicted verdict
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Write all registers back to back; narrow ones get junk above their width
    task automatic load_config(input t_cfg c);
        t_cfg_idx    order [8];
        logic [63:0] vals [8];
        logic [63:0] junk;
        junk = rand64();
        order = '{CFG_TOTAL_SECTORS, CFG_MAX_BLOCKS, CFG_ALIGN_LOG2, CFG_SIZES_NONZERO,
                  CFG_SECTOR_SIZE_MATCH, CFG_MEDIA_PRESENT, CFG_MEDIA_READ_ONLY,
                  CFG_DEVICE_READ_ONLY};
        vals[0] = c.total_sectors;
        vals[1] = {junk[63:16], c.max_blocks};
        vals[2] = {junk[63:5], c.align_log2};
        vals[3] = {junk[63:1], c.sizes_nonzero};
        vals[4] = {junk[63:1], c.sector_size_match};
        vals[5] = {junk[63:1], c.media_present};
        vals[6] = {junk[63:1], c.media_read_only};
        vals[7] = {junk[63:1], c.device_read_only};
        for (int k = 0; k < 8; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= order[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_cfg c;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers at reset: nothing is usable
        send_beat(cmd_req(ACT_DIRECT, 8'd0, 64'd0, 16'd1, 1'b0, 64'd0));
        send_beat(entry_req(8'd16, 64'd0, 64'd10, 1'b0));
        send_beat(noise_req(ACT_UNUSED));
        send_beat(cmd_req(ACT_PART, 8'd0, 64'd0, 16'd1, 1'b0, 64'd0));
        send_beat(cmd_req(ACT_PART, 8'd0, 64'd0, 16'd1, 1'b1, 64'd0));
        drain();

        // Healthy device: 1000 sectors, 64 blocks max, 8-byte alignment
        c = phase_config(0);
        c.total_sectors = 64'd1000;
        c.max_blocks = 16'd64;
        c.align_log2 = 5'd3;
        load_config(c);
        send_beat(cmd_req(ACT_PART, 8'd5, 64'd0, 16'd1, 1'b0, 64'd0));
        send_beat(cmd_req(ACT_PART, 8'd255, 64'd0, 16'd1, 1'b0, 64'd0));
        send_beat(entry_req(8'd0, 64'd0, 64'd100, 1'b0));
        send_beat(entry_req(8'd15, 64'd900, 64'd100, 1'b1));
        send_beat(entry_req(8'd1, 64'hFFFF_FFFF_FFFF_FFF6, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
        send_beat(entry_req(8'd2, 64'd200, 64'd0, 1'b0));
        send_beat(entry_req(8'd255, 64'd0, 64'd1, 1'b1));
        send_beat(cmd_req(ACT_PART, 8'd0, 64'd0, 16'd10, 1'b0, 64'd0));
        send_beat(cmd_req(ACT_PART, 8'd0, 64'd90, 16'd10, 1'b1, 64'd8));
        send_beat(cmd_req(ACT_PART, 8'd0, 64'd91, 16'd10, 1'b0, 64'd0));
        send_beat(cmd_req(ACT_PART, 8'd0, 64'd100, 16'd0, 1'b0, 64'd0));
        send_beat(cmd_req(ACT_PART, 8'd15, 64'd0, 16'd1, 1'b1, 64'd0));
        send_beat(cmd_req(ACT_PART, 8'd15, 64'd99, 16'd1, 1'b0, 64'hFFFF_FFFF_FFFF_FFF8));
        send_beat(cmd_req(ACT_PART, 8'd1, 64'd20, 16'd1, 1'b0, 64'd0));
        send_beat(cmd_req(ACT_PART, 8'd2, 64'd0, 16'd0, 1'b0, 64'd0));
        send_beat(cmd_req(ACT_PART, 8'd0, 64'd0, 16'd1, 1'b0, 64'd4));
        send_beat(cmd_req(ACT_DIRECT, 8'd0, 64'd936, 16'd64, 1'b1, 64'd0));
        send_beat(cmd_req(ACT_DIRECT, 8'd0, 64'd1000, 16'd1, 1'b0, 64'd0));
        send_beat(cmd_req(ACT_DIRECT, 8'd0, 64'd0, 16'd65, 1'b0, 64'd0));
        send_beat(cmd_req(ACT_DIRECT, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1,
                          64'hFFFF_FFFF_FFFF_FFFF));

        // Random phases, each under its own register setting and one of three idle patterns
        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            load_config(phase_config(ph));
            case (ph % 4)
                1: sender_idle_pct = 45;
                3: sender_idle_pct = 18;
                default: sender_idle_pct = 0;
            endcase
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                if (n == BEATS_PER_PHASE / 2)
                    drain();
                send_beat(next_item());
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("partition_block_request_checker verification clean");
        else
            $display("partition_block_request_checker verification failed");
        $finish;
    end

endmodule
